// ===== src/pbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types, format codes and per-format constants of the PCM decoder.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int unsigned MaxChannels = 256;

    localparam logic [3:0] FMT_U8  = 4'd0;
    localparam logic [3:0] FMT_S8  = 4'd1;
    localparam logic [3:0] FMT_U16 = 4'd2;
    localparam logic [3:0] FMT_S16 = 4'd3;
    localparam logic [3:0] FMT_U24 = 4'd4;
    localparam logic [3:0] FMT_S24 = 4'd5;
    localparam logic [3:0] FMT_U32 = 4'd6;
    localparam logic [3:0] FMT_S32 = 4'd7;
    localparam logic [3:0] FMT_F32 = 4'd8;
    localparam logic [3:0] FMT_F64 = 4'd9;

    localparam logic [1:0] REG_FORMAT   = 2'd0;
    localparam logic [1:0] REG_ENDIAN   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_WAIT,
        ST_PUSH
    } pbf_state_t;

    // Bytes per sample; zero for codes that name no format.
    function automatic logic [3:0] fmt_bytes(input logic [3:0] fmt);
        logic [3:0] n;
        unique case (fmt)
            FMT_U8, FMT_S8:   n = 4'd1;
            FMT_U16, FMT_S16: n = 4'd2;
            FMT_U24, FMT_S24: n = 4'd3;
            FMT_U32, FMT_S32,
            FMT_F32:          n = 4'd4;
            FMT_F64:          n = 4'd8;
            default:          n = 4'd0;
        endcase
        return n;
    endfunction

    // Weight of the sign bit of an integer format.
    function automatic logic [31:0] fmt_half(input logic [3:0] fmt);
        logic [31:0] h;
        unique case (fmt)
            FMT_U8, FMT_S8:   h = 32'h0000_0080;
            FMT_U16, FMT_S16: h = 32'h0000_8000;
            FMT_U24, FMT_S24: h = 32'h0080_0000;
            default:          h = 32'h8000_0000;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== src/pbf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_div
// Bit-serial correctly rounded single of a magnitude over an odd divisor.
// ----------------------------------------------------------------------------
module pbf_div
    import pbf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] mag,
    input  wire logic [31:0] divisor,
    input  wire logic        neg,
    output logic             done,
    output logic [31:0]      result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [23:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  s_reg, s_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;

    logic [32:0] r2;
    logic        ge;
    logic [24:0] qr;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        s_next    = s_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        r2 = {r_reg, 1'b0};
        ge = (r2 >= {1'b0, d_reg});
        qr = {1'b0, q_reg} + {24'd0, (r2 > {1'b0, d_reg})};
        if (start) begin
            d_next   = divisor;
            neg_next = neg;
            s_next   = '0;
            if (mag == '0) begin
                res_next  = '0;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                if (mag >= divisor) begin
                    q_next = 24'd1;
                    r_next = mag - divisor;
                end else begin
                    q_next = '0;
                    r_next = mag;
                end
            end
        end else if (busy_reg) begin
            if (q_reg[23]) begin
                // Round to nearest; the divisor is odd so no tie occurs.
                busy_next = 1'b0;
                done_next = 1'b1;
                if (qr[24]) begin
                    res_next = {neg_reg, 8'(9'd151 - {3'd0, s_reg}), 23'd0};
                end else begin
                    res_next = {neg_reg, 8'(9'd150 - {3'd0, s_reg}), qr[22:0]};
                end
            end else begin
                q_next = {q_reg[22:0], ge};
                r_next = ge ? 32'(r2 - {1'b0, d_reg}) : r2[31:0];
                s_next = s_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        s_reg   <= s_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== src/pbf_dnorm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbf_dnorm
// Bit-serial rounding of a double to single, nearest-even.
// ----------------------------------------------------------------------------
module pbf_dnorm
    import pbf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dbl,
    output logic             done,
    output logic [31:0]      result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [52:0] m_reg, m_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        guard_reg, guard_next;
    logic        sticky_reg, sticky_next;
    logic        norm_reg, norm_next;
    logic [10:0] ebase_reg, ebase_next;
    logic        sign_reg, sign_next;
    logic [31:0] res_reg, res_next;

    logic [10:0] ex;
    logic [24:0] q1;
    logic [34:0] bits;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        m_next      = m_reg;
        cnt_next    = cnt_reg;
        guard_next  = guard_reg;
        sticky_next = sticky_reg;
        norm_next   = norm_reg;
        ebase_next  = ebase_reg;
        sign_next   = sign_reg;
        res_next    = res_reg;
        ex   = dbl[62:52];
        q1   = m_reg[24:0] + {24'd0, guard_reg & (sticky_reg | m_reg[0])};
        bits = {1'b0, ebase_reg, 23'd0} + {10'd0, q1};
        if (start) begin
            sign_next = dbl[63];
            if (ex == 11'h7ff) begin
                done_next = 1'b1;
                res_next  = (dbl[51:0] == '0) ? {dbl[63], 31'h7f80_0000}
                                              : {dbl[63], 8'hff, 1'b1, dbl[50:29]};
            end else if (ex < 11'd866) begin
                // Zero, or too small for even the least subnormal.
                done_next = 1'b1;
                res_next  = {dbl[63], 31'd0};
            end else begin
                busy_next   = 1'b1;
                m_next      = {1'b1, dbl[51:0]};
                guard_next  = 1'b0;
                sticky_next = 1'b0;
                norm_next   = (ex >= 11'd897);
                ebase_next  = 11'(ex - 11'd897);
                cnt_next    = (ex >= 11'd897) ? 6'd29 : 6'(11'd926 - ex);
            end
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                sticky_next = sticky_reg | guard_reg;
                guard_next  = m_reg[0];
                m_next      = {1'b0, m_reg[52:1]};
                cnt_next    = cnt_reg - 6'd1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!norm_reg) begin
                    res_next = {sign_reg, 6'd0, q1};
                end else if (bits >= 35'h0_7f80_0000) begin
                    res_next = {sign_reg, 31'h7f80_0000};
                end else begin
                    res_next = {sign_reg, bits[30:0]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        m_reg      <= m_next;
        cnt_reg    <= cnt_next;
        guard_reg  <= guard_next;
        sticky_reg <= sticky_next;
        norm_reg   <= norm_next;
        ebase_reg  <= ebase_next;
        sign_reg   <= sign_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== src/pcm_bytes_to_float_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_bytes_to_float_decoder_unit
// Assembles interleaved PCM bytes into samples and converts each to single.
// ----------------------------------------------------------------------------
// Channel  | Direction | Carries
// s_       | in        | tdata[7:0] data_byte, tlast end_of_data
// m_       | out       | tdata[31:0] sample_bits, [39:32] channel_index,
//          |           | tlast frame_done, tuser[0] has_sample, [1] truncated
// cfg_     | in        | index 0 format code, 1 big_endian, 2 channels
//
// A byte that completes no sample is simply taken; one that only ends a cut
// frame passes through ST_PUSH to reach the output register. A completed
// sample is accepted in ST_IDLE and prepared in ST_CONV, then the serial unit:
// integer formats run the bit-serial divider, one quotient bit a cycle;
// f64 runs the serial rounding shifter; f32 needs none. ST_WAIT then hands
// the result to the output stage and ST_PUSH moves it into the output
// register once that is free; f32 skips the hand-over.
// Reset is synchronous and active low and clears the framing and control.
// The input is taken again as soon as the result sits in the output
// register, so a stalled consumer holds back only the next item bound for the output.
// ----------------------------------------------------------------------------
module pcm_bytes_to_float_decoder_unit
    import pbf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_data
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] sample_bits, [39:32] channel_index
    output logic             m_tlast,   // frame_done
    output logic [1:0]       m_tuser,   // [0] has_sample, [1] truncated
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    pbf_state_t  state_reg, state_next;

    logic [3:0]  fmt_reg, fmt_next;
    logic        be_reg, be_next;
    logic [8:0]  chans_reg, chans_next;

    logic [63:0] word_reg, word_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  chan_reg, chan_next;

    logic [63:0] samp_reg, samp_next;
    logic [31:0] pbits_reg, pbits_next;
    logic [7:0]  pchan_reg, pchan_next;
    logic        pdone_reg, pdone_next;
    logic        pfdone_reg, pfdone_next;
    logic        ptrunc_reg, ptrunc_next;

    logic        ovalid_reg, ovalid_next;
    logic [39:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;
    logic [1:0]  ouser_reg, ouser_next;

    logic        accept, cfg_write, out_load;
    logic [3:0]  nb;
    logic [8:0]  fch;
    logic [63:0] asm_word;
    logic        complete, fdone_now, trunc_now;
    logic [2:0]  pos_after;
    logic [7:0]  chan_after;

    logic [31:0] half, mask, raw;
    logic [32:0] mag33;
    logic        neg;
    logic        div_start, dn_start, div_done, dn_done;
    logic [31:0] div_res, dn_res;

    assign accept    = s_tvalid && s_tready;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_PUSH) && (!ovalid_reg || m_tready);

    // Framing: byte placement, sample completion and channel count.
    always_comb begin
        nb  = fmt_bytes(fmt_reg);
        if (chans_reg == '0) begin
            fch = 9'd1;
        end else if (chans_reg > 9'(MaxChannels)) begin
            fch = 9'(MaxChannels);
        end else begin
            fch = chans_reg;
        end
        asm_word = word_reg;
        if (be_reg && nb > 4'd1) begin
            asm_word = {word_reg[55:0], s_tdata};
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (pos_reg == 3'(i)) begin
                    asm_word[8*i +: 8] = word_reg[8*i +: 8] | s_tdata;
                end
            end
        end
        complete   = (nb != '0) && ({1'b0, pos_reg} + 4'd1 >= nb);
        fdone_now  = complete && ({1'b0, chan_reg} + 9'd1 >= fch);
        pos_after  = pos_reg;
        chan_after = chan_reg;
        if (nb != '0) begin
            if (complete) begin
                pos_after  = '0;
                chan_after = fdone_now ? 8'd0 : 8'(chan_reg + 8'd1);
            end else begin
                pos_after = pos_reg + 3'd1;
            end
        end
        trunc_now = s_tlast && ((pos_after != '0) || (chan_after != '0));
    end

    // Integer magnitude and sign from the completed word.
    always_comb begin
        half  = fmt_half(fmt_reg);
        mask  = 32'({half, 1'b0} - 33'd1);
        raw   = samp_reg[31:0] & mask;
        if (!fmt_reg[0]) begin
            raw = raw ^ half;
        end
        neg   = |(raw & half);
        mag33 = neg ? ({half, 1'b0} - {1'b0, raw}) : {1'b0, raw};
    end

    always_comb begin
        state_next  = state_reg;
        fmt_next    = fmt_reg;
        be_next     = be_reg;
        chans_next  = chans_reg;
        word_next   = word_reg;
        pos_next    = pos_reg;
        chan_next   = chan_reg;
        samp_next   = samp_reg;
        pbits_next  = pbits_reg;
        pchan_next  = pchan_reg;
        pdone_next  = pdone_reg;
        pfdone_next = pfdone_reg;
        ptrunc_next = ptrunc_reg;
        div_start   = 1'b0;
        dn_start    = 1'b0;

        if (cfg_write) begin
            unique case (cfg_index)
                REG_FORMAT:   fmt_next   = cfg_data[3:0];
                REG_ENDIAN:   be_next    = cfg_data[0];
                REG_CHANNELS: chans_next = cfg_data;
                default:      ;
            endcase
            if ((cfg_index == REG_FORMAT) || (cfg_index == REG_ENDIAN)
                    || (cfg_index == REG_CHANNELS)) begin
                word_next = '0;
                pos_next  = '0;
                chan_next = '0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pchan_next  = chan_reg;
                    pdone_next  = complete;
                    pfdone_next = fdone_now;
                    ptrunc_next = trunc_now;
                    pbits_next  = '0;
                    samp_next   = asm_word;
                    word_next   = complete ? 64'd0 : asm_word;
                    pos_next    = pos_after;
                    chan_next   = chan_after;
                    if (s_tlast) begin
                        word_next = '0;
                        pos_next  = '0;
                        chan_next = '0;
                    end
                    if (complete) begin
                        state_next = ST_CONV;
                    end else if (trunc_now) begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_CONV: begin
                if (fmt_reg == FMT_F32) begin
                    pbits_next = samp_reg[31:0];
                    state_next = ST_PUSH;
                end else if (fmt_reg == FMT_F64) begin
                    dn_start   = 1'b1;
                    state_next = ST_WAIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    pbits_next = div_res;
                    state_next = ST_PUSH;
                end else if (dn_done) begin
                    pbits_next = dn_res;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ouser_next  = ouser_reg;
        if (out_load) begin
            ovalid_next = 1'b1;
            odata_next  = {pchan_reg, pbits_reg};
            olast_next  = pfdone_reg;
            ouser_next  = {ptrunc_reg, pdone_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fmt_reg    <= FMT_U8;
            be_reg     <= 1'b0;
            chans_reg  <= 9'd1;
            word_reg   <= '0;
            pos_reg    <= '0;
            chan_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fmt_reg    <= fmt_next;
            be_reg     <= be_next;
            chans_reg  <= chans_next;
            word_reg   <= word_next;
            pos_reg    <= pos_next;
            chan_reg   <= chan_next;
            ovalid_reg <= ovalid_next;
        end
        samp_reg   <= samp_next;
        pbits_reg  <= pbits_next;
        pchan_reg  <= pchan_next;
        pdone_reg  <= pdone_next;
        pfdone_reg <= pfdone_next;
        ptrunc_reg <= ptrunc_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
        ouser_reg  <= ouser_next;
    end

    pbf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (mag33[31:0]),
        .divisor (half - 32'd1),
        .neg     (neg),
        .done    (div_done),
        .result  (div_res)
    );

    pbf_dnorm u_dnorm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dn_start),
        .dbl     (samp_reg),
        .done    (dn_done),
        .result  (dn_res)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'b00))
        else $error("result item carries neither a sample nor truncation");

    a_chan_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, chan_reg} < fch) || (chan_reg == 8'd0) || $past(cfg_write))
        else $error("channel counter beyond frame size");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_done && dn_done))
        else $error("both conversion units finished together");

    a_load_from_push: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == ST_IDLE) && m_tvalid)
        else $error("output load did not complete the item");

endmodule
`default_nettype wire
